>>> rtl/core/swrb_pkg.sv
// Shared types and constants for the sliding-window rate budget block.
// No dependencies; compile first.
package swrb_pkg;

	localparam int RING_DEPTH = 16;
	localparam int IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int CNT_W      = $clog2(RING_DEPTH + 1);

	localparam int TIME_W     = 64;
	localparam int WIN_W      = 48;
	localparam int ALLOW_W    = 16;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 48;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_ALLOWED = CFG_IDX_W'(1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PUSH
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;   // capture event time, clear scan state
		logic record;   // write stamp at head, advance head
		logic scan;     // examine one ring slot
		logic load;     // load result register
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic disabled;  // window or allowance is zero
		logic scan_last; // current slot is the last one
		logic out_free;  // result register can take a value
	} dp_sts_t;

endpackage

>>> rtl/core/swrb_evt_if.sv
// Event channel: valid/ready handshake carrying one timestamp.
// Depends on swrb_pkg.
interface swrb_evt_if;
	import swrb_pkg::*;

	logic              valid;
	logic              ready;
	logic [TIME_W-1:0] event_time_ns;

	modport source (output valid, output event_time_ns, input ready);
	modport sink   (input valid, input event_time_ns, output ready);

endinterface

>>> rtl/core/swrb_res_if.sv
// Result channel: valid/ready handshake carrying the budget flag.
// Depends on swrb_pkg (for consistency of imports only).
interface swrb_res_if;
	import swrb_pkg::*;

	logic valid;
	logic ready;
	logic budget_spent;

	modport source (output valid, output budget_spent, input ready);
	modport sink   (input valid, input budget_spent, output ready);

endinterface

>>> rtl/core/swrb_ctrl.sv
// Controller state machine: accept, scan the ring, hand over the result.
// Depends on swrb_pkg.
module swrb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  swrb_pkg::dp_sts_t sts,
	output swrb_pkg::dp_cmd_t cmd
);
	import swrb_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = sts.disabled ? ST_PUSH : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.scan_last) begin
					state_d = ST_PUSH;
				end
			end
			ST_PUSH: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		cmd        = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				cmd.record = in_valid & ~sts.disabled;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
			end
			ST_PUSH: begin
				cmd.load = sts.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// a transfer in closes the input until the result has been loaded
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> !in_ready)
		else $error("input still open after transfer");

	// the scan ends in the hand-over state
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) && sts.scan_last |=> state_q == ST_PUSH)
		else $error("scan did not end in hand-over");

	// recording only ever happens with an enabled limiter
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.record |-> cmd.accept && !sts.disabled)
		else $error("record on disabled limiter");

endmodule

>>> rtl/core/swrb_dp.sv
// Datapath: config registers, stamp ring with valid bits, write head,
// scan counter, in-window tally and result register. Depends on swrb_pkg.
module swrb_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [swrb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [swrb_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic [swrb_pkg::TIME_W-1:0]     event_time_ns,
	input  swrb_pkg::dp_cmd_t               cmd,
	output swrb_pkg::dp_sts_t               sts,
	output logic                            res_valid,
	input  logic                            res_ready,
	output logic                            res_spent
);
	import swrb_pkg::*;

	logic [WIN_W-1:0]   win_q;
	logic [ALLOW_W-1:0] allow_q;

	logic [TIME_W-1:0]  ring_q [RING_DEPTH];
	logic [RING_DEPTH-1:0] vld_q;
	logic [IDX_W-1:0]   head_q;
	logic [IDX_W-1:0]   k_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [TIME_W-1:0]  now_q;
	logic               dis_q;
	logic               out_valid_q;
	logic               out_spent_q;

	logic [TIME_W-1:0]  stamp;
	logic [TIME_W:0]    diff;
	logic               hit;
	logic               last_k;
	logic               last_head;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q   <= '0;
			allow_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_WINDOW) begin
				win_q <= cfg_wdata[WIN_W-1:0];
			end else if (cfg_index == REG_ALLOWED) begin
				allow_q <= cfg_wdata[ALLOW_W-1:0];
			end
		end
	end

	assign last_k    = (k_q == IDX_W'(RING_DEPTH - 1));
	assign last_head = (head_q == IDX_W'(RING_DEPTH - 1));

	// empty slots read as zero
	assign stamp = vld_q[k_q] ? ring_q[k_q] : '0;
	assign diff  = {1'b0, now_q} - {1'b0, stamp};
	// borrow: stamp later than now, counts as inside
	assign hit   = (stamp != '0) &&
		(diff[TIME_W] ||
		 ((diff[TIME_W-1:WIN_W] == '0) && (diff[WIN_W-1:0] <= win_q)));

	// ring payload, no reset
	always_ff @(posedge clk) begin
		if (cmd.record) begin
			ring_q[head_q] <= event_time_ns;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			head_q <= '0;
		end else if (cmd.record) begin
			vld_q[head_q] <= 1'b1;
			head_q        <= last_head ? '0 : head_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			now_q <= event_time_ns;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q   <= '0;
			cnt_q <= '0;
			dis_q <= 1'b0;
		end else if (cmd.accept) begin
			k_q   <= '0;
			cnt_q <= '0;
			dis_q <= sts.disabled;
		end else if (cmd.scan) begin
			k_q   <= last_k ? '0 : k_q + 1'b1;
			cnt_q <= cnt_q + CNT_W'(hit);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_spent_q <= dis_q | (ALLOW_W'(cnt_q) > allow_q);
		end
	end

	assign sts.disabled  = (win_q == '0) || (allow_q == '0);
	assign sts.scan_last = last_k;
	assign sts.out_free  = ~out_valid_q | res_ready;

	assign res_valid = out_valid_q;
	assign res_spent = out_spent_q;

	// tally can never pass the ring size
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(RING_DEPTH))
		else $error("tally overflow");

	// a recorded slot is marked valid
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.record |=> vld_q[$past(head_q)])
		else $error("recorded slot not valid");

	// a load always presents a result
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> out_valid_q)
		else $error("loaded result not presented");

endmodule

>>> rtl/core/sliding_window_rate_budget.sv
// Sliding-window rate budget: one result transfer per event transfer.
// Latency: from the event transfer through the ring scan and the push state
// to the result register; a disabled limiter (window or allowance zero) skips the scan.
// Pacing: a new event is taken only once the previous result is loaded, set by the one-slot-a-cycle
// scan of the stamp ring through a single subtract-and-compare unit, which a
// disabled limiter skips. A result left waiting holds the next load (push) off until taken.
// Reset (arst_n low): ring emptied via valid bits, head, config and handshake cleared.
module sliding_window_rate_budget (
	input  logic                            clk,
	input  logic                            arst_n,
	swrb_evt_if.sink                        evt,
	swrb_res_if.source                      res,
	input  logic                            cfg_we,
	input  logic [swrb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [swrb_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import swrb_pkg::*;

	// Command and status between the controller and the datapath.
	// accept: the event transfer; record: stamp written at the head
	// (skipped when the limiter is disabled); scan: one ring slot examined
	// per cycle; load: result register written when it is free.
	dp_cmd_t cmd;
	dp_sts_t sts;
	logic    in_ready;

	// Controller: idle -> scan (one pass over all RING_DEPTH slots) -> push -> idle.
	// A disabled limiter skips the scan and reports spent directly.
	swrb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (evt.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	assign evt.ready = in_ready;

	// Datapath: the stamp just written is part of the scan, so the count
	// includes the current event. A zero stamp marks an empty slot, and a
	// stamp later than the event time (clock stepped back) counts as inside.
	// The result register lets a finished result wait for the sink while
	// the controller returns to idle.
	swrb_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.event_time_ns (evt.event_time_ns),
		.cmd           (cmd),
		.sts           (sts),
		.res_valid     (res.valid),
		.res_ready     (res.ready),
		.res_spent     (res.budget_spent)
	);

endmodule
